>>> rtl/core/tcv_pkg.sv
package tcv_pkg;

  // Datapath widths
  localparam int COORD_W  = 32;               // Q16.16 coordinate
  localparam int NUM_W    = 2 * COORD_W;      // divider numerator
  localparam int SIZE_W   = 13;               // screen width / height
  localparam int EDGE_W   = COORD_W + 1;      // vertex difference
  localparam int PROD_W   = 2 * EDGE_W;       // edge product
  localparam int NRM_W    = PROD_W + 1;       // normal component
  localparam int LO_W     = EDGE_W + 1;       // low slice of a normal component
  localparam int HI_W     = NRM_W - LO_W;     // high slice of a normal component
  localparam int PLO_W    = LO_W + 1 + COORD_W;
  localparam int PHI_W    = HI_W + COORD_W;
  localparam int CMP_W    = PHI_W + LO_W + 1; // one term of the dot product
  localparam int DOT_W    = CMP_W + 2;        // full dot product

  // Pipeline depths
  localparam int LAT_FRONT = 2;
  localparam int LAT_CULL  = 6;
  localparam int DIV_STEPS = COORD_W;
  localparam int LAT_DIV   = DIV_STEPS + 3;
  localparam int LAT_TOTAL = LAT_FRONT + LAT_DIV;

  // Register map
  localparam int CFG_AW = 4;
  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_CULL_ENABLE   = 2'd2,
    REG_CLIP_ENABLE   = 2'd3
  } cfg_idx_t;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(480);

  localparam logic [COORD_W-1:0] SAT_POS = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] SAT_NEG = {1'b1, {(COORD_W-1){1'b0}}};

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NUM_W-1:0]   num_t;

  // Triangle rejection flags from the cull unit
  typedef struct packed {
    logic back;
    logic outside;
  } tcv_cull_t;

  function automatic logic [COORD_W-1:0] abs_coord(input logic [COORD_W-1:0] v);
    abs_coord = v[COORD_W-1] ? (~v + COORD_W'(1)) : v;
  endfunction

endpackage

>>> rtl/core/tcv_front.sv
module tcv_front (
  input  logic                           clk,
  input  logic                           en,
  input  tcv_pkg::coord_t                vtx [12],
  input  logic [tcv_pkg::SIZE_W-1:0]     width,
  input  logic [tcv_pkg::SIZE_W-1:0]     height,
  output tcv_pkg::num_t                  num [9],
  output tcv_pkg::coord_t                den [3]
);

  logic signed [tcv_pkg::EDGE_W-1:0] sumx_r [3];
  logic signed [tcv_pkg::EDGE_W-1:0] sumy_r [3];
  tcv_pkg::coord_t                   z_r    [3];
  tcv_pkg::coord_t                   w_r    [3];
  tcv_pkg::num_t                     num_r  [9];
  tcv_pkg::coord_t                   den_r  [3];

  localparam int PX_W = tcv_pkg::EDGE_W + tcv_pkg::SIZE_W + 1;

  logic signed [PX_W-1:0] px [3];
  logic signed [PX_W-1:0] py [3];

  // Stage A: x+w and w-y
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sumx_r[k] <= tcv_pkg::EDGE_W'(vtx[4*k]) + tcv_pkg::EDGE_W'(vtx[4*k+3]);
        sumy_r[k] <= tcv_pkg::EDGE_W'(vtx[4*k+3]) - tcv_pkg::EDGE_W'(vtx[4*k+1]);
        z_r[k]    <= vtx[4*k+2];
        w_r[k]    <= vtx[4*k+3];
      end
    end
  end

  // Scale by screen size
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      px[k] = sumx_r[k] * $signed({1'b0, width});
      py[k] = sumy_r[k] * $signed({1'b0, height});
    end
  end

  // Stage B: numerators, half size folded into the shift
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num_r[3*k]   <= {{(tcv_pkg::NUM_W-PX_W-15){px[k][PX_W-1]}}, px[k], 15'd0};
        num_r[3*k+1] <= {{(tcv_pkg::NUM_W-PX_W-15){py[k][PX_W-1]}}, py[k], 15'd0};
        num_r[3*k+2] <= {{(tcv_pkg::NUM_W-tcv_pkg::COORD_W-16){z_r[k][tcv_pkg::COORD_W-1]}},
                         z_r[k], 16'd0};
        den_r[k]     <= w_r[k];
      end
    end
  end

  assign num = num_r;
  assign den = den_r;

endmodule

>>> rtl/core/tcv_cull.sv
module tcv_cull (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  tcv_pkg::coord_t    vtx [12],
  output tcv_pkg::tcv_cull_t flags
);

  logic signed [tcv_pkg::EDGE_W-1:0]  e1_r [3];
  logic signed [tcv_pkg::EDGE_W-1:0]  e2_r [3];
  logic signed [tcv_pkg::PROD_W-1:0]  p_r  [6];
  logic signed [tcv_pkg::NRM_W-1:0]   n_r  [3];
  logic signed [tcv_pkg::PLO_W-1:0]   lo_r [3];
  logic signed [tcv_pkg::PHI_W-1:0]   hi_r [3];
  logic signed [tcv_pkg::CMP_W-1:0]   c_r  [3];
  tcv_pkg::coord_t                    v0_r [3][3];
  logic [4:0]                         out_r;
  tcv_pkg::tcv_cull_t                 flags_r;

  logic                               in_vtx [3];
  logic [tcv_pkg::COORD_W-1:0]        aw     [3];
  logic signed [tcv_pkg::DOT_W-1:0]   dot;

  // Frustum test per vertex
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      aw[k]     = tcv_pkg::abs_coord(vtx[4*k+3]);
      in_vtx[k] = (tcv_pkg::abs_coord(vtx[4*k])   < aw[k]) &&
                  (tcv_pkg::abs_coord(vtx[4*k+1]) < aw[k]) &&
                  (tcv_pkg::abs_coord(vtx[4*k+2]) < aw[k]);
    end
  end

  // Registered stages in order: edges, products, normal, partial dot products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i]    <= tcv_pkg::EDGE_W'(vtx[4+i]) - tcv_pkg::EDGE_W'(vtx[i]);
        e2_r[i]    <= tcv_pkg::EDGE_W'(vtx[8+i]) - tcv_pkg::EDGE_W'(vtx[i]);
        v0_r[0][i] <= vtx[i];
        v0_r[1][i] <= v0_r[0][i];
        v0_r[2][i] <= v0_r[1][i];
      end
      out_r[0] <= !(in_vtx[0] || in_vtx[1] || in_vtx[2]);
      out_r[4:1] <= out_r[3:0];
      p_r[0] <= e1_r[1] * e2_r[2];
      p_r[1] <= e1_r[2] * e2_r[1];
      p_r[2] <= e1_r[2] * e2_r[0];
      p_r[3] <= e1_r[0] * e2_r[2];
      p_r[4] <= e1_r[0] * e2_r[1];
      p_r[5] <= e1_r[1] * e2_r[0];
      for (int i = 0; i < 3; i++) begin
        n_r[i]  <= $signed({p_r[2*i][tcv_pkg::PROD_W-1], p_r[2*i]}) -
                   $signed({p_r[2*i+1][tcv_pkg::PROD_W-1], p_r[2*i+1]});
        lo_r[i] <= $signed({1'b0, n_r[i][tcv_pkg::LO_W-1:0]}) * v0_r[2][i];
        hi_r[i] <= $signed(n_r[i][tcv_pkg::NRM_W-1:tcv_pkg::LO_W]) * v0_r[2][i];
        // Recombine the slices
        c_r[i]  <= $signed({hi_r[i][tcv_pkg::PHI_W-1], hi_r[i], {tcv_pkg::LO_W{1'b0}}}) +
                   $signed({{(tcv_pkg::CMP_W-tcv_pkg::PLO_W){lo_r[i][tcv_pkg::PLO_W-1]}},
                            lo_r[i]});
      end
    end
  end

  // Sum and sign
  assign dot = tcv_pkg::DOT_W'(c_r[0]) + tcv_pkg::DOT_W'(c_r[1]) + tcv_pkg::DOT_W'(c_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (en) begin
      flags_r.back    <= !dot[tcv_pkg::DOT_W-1] && (dot != '0);
      flags_r.outside <= out_r[4];
    end
  end

  assign flags = flags_r;

endmodule

>>> rtl/core/tcv_div.sv
module tcv_div (
  input  logic            clk,
  input  logic            en,
  input  tcv_pkg::num_t   num,
  input  tcv_pkg::coord_t den,
  output tcv_pkg::coord_t quo
);

  localparam int CW = tcv_pkg::COORD_W;
  localparam int NW = tcv_pkg::NUM_W;
  localparam int NS = tcv_pkg::DIV_STEPS;

  // Setup stage
  logic [NW-1:0] nmag_r;
  logic [CW-1:0] dmag1_r;
  logic          neg1_r;
  logic          zero1_r;

  // Step stages
  logic [CW-1:0] rem_r  [NS+1];
  logic [CW-1:0] acc_r  [NS+1];
  logic [CW-1:0] dmag_r [NS+1];
  logic          neg_r  [NS+1];
  logic          zero_r [NS+1];
  logic          ovf_r  [NS+1];

  logic [CW-1:0] quo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nmag_r  <= num[NW-1] ? (~num + NW'(1)) : num;
      dmag1_r <= tcv_pkg::abs_coord(den);
      neg1_r  <= num[NW-1] ^ den[CW-1];
      zero1_r <= (num == '0);
    end
  end

  // Overflow check; high half seeds the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= nmag_r[NW-1:CW];
      acc_r[0]  <= nmag_r[CW-1:0];
      dmag_r[0] <= dmag1_r;
      neg_r[0]  <= neg1_r;
      zero_r[0] <= zero1_r;
      ovf_r[0]  <= nmag_r >= {dmag1_r, {CW{1'b0}}};
    end
  end

  // One restoring quotient bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [CW:0] trial;
    logic        ge;
    assign trial = {rem_r[k], acc_r[k][CW-1]};
    assign ge    = trial >= {1'b0, dmag_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? CW'(trial - {1'b0, dmag_r[k]}) : trial[CW-1:0];
        acc_r[k+1]  <= {acc_r[k][CW-2:0], ge};
        dmag_r[k+1] <= dmag_r[k];
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
        ovf_r[k+1]  <= ovf_r[k];
      end
    end
  end

  // Zero, sign and saturation
  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_r[NS]) begin
        quo_r <= '0;
      end else if (ovf_r[NS]) begin
        quo_r <= neg_r[NS] ? tcv_pkg::SAT_NEG : tcv_pkg::SAT_POS;
      end else if (neg_r[NS]) begin
        quo_r <= (acc_r[NS] > tcv_pkg::SAT_NEG) ? tcv_pkg::SAT_NEG : (~acc_r[NS] + CW'(1));
      end else begin
        quo_r <= acc_r[NS][CW-1] ? tcv_pkg::SAT_POS : acc_r[NS];
      end
    end
  end

  assign quo = quo_r;

endmodule

>>> rtl/core/triangle_cull_and_viewport.sv
// Triangle cull, clip test, perspective divide and viewport mapping.
// The path from input transfer to result runs through 2 front stages and 35 divider stages.
// Throughput: one triangle per cycle unless a held result stalls it; bit-per-stage dividers, nine in parallel.
// Culled or clipped triangles produce no result transfer.
// Reset (rst_n low, synchronous) empties the pipeline and loads W=640, H=480, cull/clip off.
module triangle_cull_and_viewport (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [31:0]         in_v0_x,
  input  logic signed [31:0]         in_v0_y,
  input  logic signed [31:0]         in_v0_z,
  input  logic signed [31:0]         in_v0_w,
  input  logic signed [31:0]         in_v1_x,
  input  logic signed [31:0]         in_v1_y,
  input  logic signed [31:0]         in_v1_z,
  input  logic signed [31:0]         in_v1_w,
  input  logic signed [31:0]         in_v2_x,
  input  logic signed [31:0]         in_v2_y,
  input  logic signed [31:0]         in_v2_z,
  input  logic signed [31:0]         in_v2_w,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         out_s0_x,
  output logic signed [31:0]         out_s0_y,
  output logic signed [31:0]         out_s0_z,
  output logic signed [31:0]         out_s1_x,
  output logic signed [31:0]         out_s1_y,
  output logic signed [31:0]         out_s1_z,
  output logic signed [31:0]         out_s2_x,
  output logic signed [31:0]         out_s2_y,
  output logic signed [31:0]         out_s2_z,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tcv_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int LT = tcv_pkg::LAT_TOTAL;
  localparam int LC = tcv_pkg::LAT_CULL;

  logic [tcv_pkg::SIZE_W-1:0] width_r;
  logic [tcv_pkg::SIZE_W-1:0] height_r;
  logic                       cull_en_r;
  logic                       clip_en_r;

  logic                       adv;
  logic                       drop;
  logic [LT-1:0]              vld_r;

  tcv_pkg::coord_t            vtx  [12];
  tcv_pkg::num_t              num  [9];
  tcv_pkg::coord_t            den  [3];
  tcv_pkg::coord_t            quo  [9];
  tcv_pkg::tcv_cull_t         cflags;
  tcv_pkg::cfg_idx_t          cfg_idx;

  // Register writes
  assign pready  = 1'b1;
  assign cfg_idx = tcv_pkg::cfg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= tcv_pkg::WIDTH_RST;
      height_r  <= tcv_pkg::HEIGHT_RST;
      cull_en_r <= 1'b0;
      clip_en_r <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        tcv_pkg::REG_SCREEN_WIDTH:  width_r   <= pwdata[tcv_pkg::SIZE_W-1:0];
        tcv_pkg::REG_SCREEN_HEIGHT: height_r  <= pwdata[tcv_pkg::SIZE_W-1:0];
        tcv_pkg::REG_CULL_ENABLE:   cull_en_r <= pwdata[0];
        tcv_pkg::REG_CLIP_ENABLE:   clip_en_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (cfg_idx)
      tcv_pkg::REG_SCREEN_WIDTH:  prdata = {{(32-tcv_pkg::SIZE_W){1'b0}}, width_r};
      tcv_pkg::REG_SCREEN_HEIGHT: prdata = {{(32-tcv_pkg::SIZE_W){1'b0}}, height_r};
      tcv_pkg::REG_CULL_ENABLE:   prdata = {31'd0, cull_en_r};
      tcv_pkg::REG_CLIP_ENABLE:   prdata = {31'd0, clip_en_r};
      default:                    prdata = '0;
    endcase
  end

  // Whole pipeline advances unless a finished result is held
  assign adv      = !(vld_r[LT-1] && out_stall);
  assign in_stall = !adv;
  assign drop     = (cull_en_r && cflags.back) || (clip_en_r && cflags.outside);

  // Valid line; rejected triangles are removed once the cull unit decides
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      for (int k = LT-1; k > 0; k--) begin
        if (k == LC) begin
          vld_r[k] <= vld_r[k-1] && !drop;
        end else begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      vld_r[0] <= in_valid;
    end
  end

  assign vtx[0]  = in_v0_x;
  assign vtx[1]  = in_v0_y;
  assign vtx[2]  = in_v0_z;
  assign vtx[3]  = in_v0_w;
  assign vtx[4]  = in_v1_x;
  assign vtx[5]  = in_v1_y;
  assign vtx[6]  = in_v1_z;
  assign vtx[7]  = in_v1_w;
  assign vtx[8]  = in_v2_x;
  assign vtx[9]  = in_v2_y;
  assign vtx[10] = in_v2_z;
  assign vtx[11] = in_v2_w;

  tcv_front u_front (
    .clk    (clk),
    .en     (adv),
    .vtx    (vtx),
    .width  (width_r),
    .height (height_r),
    .num    (num),
    .den    (den)
  );

  tcv_cull u_cull (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vtx   (vtx),
    .flags (cflags)
  );

  for (genvar i = 0; i < 9; i++) begin : g_div
    tcv_div u_div (
      .clk (clk),
      .en  (adv),
      .num (num[i]),
      .den (den[i/3]),
      .quo (quo[i])
    );
  end

  assign out_valid = vld_r[LT-1];
  assign out_s0_x  = quo[0];
  assign out_s0_y  = quo[1];
  assign out_s0_z  = quo[2];
  assign out_s1_x  = quo[3];
  assign out_s1_y  = quo[4];
  assign out_s1_z  = quo[5];
  assign out_s2_x  = quo[6];
  assign out_s2_y  = quo[7];
  assign out_s2_z  = quo[8];

  // Checks
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_no_resurrect: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !vld_r[LC-1]) |=> !vld_r[LC])
    else $error("valid appeared at the reject stage");

  a_pass_when_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !cull_en_r && !clip_en_r) |=> (vld_r[LC] == $past(vld_r[LC-1])))
    else $error("triangle dropped with culling and clipping off");

endmodule
